// ===== rtl/two_threshold_run_zero_suppressor_unit_assert.svh =====
// ---------------------------------------------------------------------------
// two_threshold_run_zero_suppressor_unit_assert.svh
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef TWO_THRESHOLD_RUN_ZERO_SUPPRESSOR_UNIT_ASSERT_SVH
`define TWO_THRESHOLD_RUN_ZERO_SUPPRESSOR_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define TTRZS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ttrzs assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define TTRZS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ttrzs assertion failed");

`endif

// ===== rtl/ttrzs_pkg.sv =====
// ---------------------------------------------------------------------------
// ttrzs_pkg
// widths, register indexes and helpers of the run zero suppressor
// ---------------------------------------------------------------------------
package ttrzs_pkg;

    localparam int SAMPLE_W  = 10;
    localparam int CNT_W     = 10;
    localparam int ZBIN_W    = 9;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_THR  = 2'd0,
        CFG_HIGH_THR = 2'd1,
        CFG_MIN_LEN  = 2'd2,
        CFG_MIN_HIGH = 2'd3
    } cfg_idx_t;

    // saturating increment, holds at all ones
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
        return r;
    endfunction

endpackage

// ===== rtl/two_threshold_run_zero_suppressor_unit.sv =====
// ---------------------------------------------------------------------------
// two_threshold_run_zero_suppressor_unit
// zero suppression of one channel's samples with a run length / high count cut
// ---------------------------------------------------------------------------
// One request is taken per clock and each one yields zero or one zeroing
// command (zero_from..zero_to, inclusive). A request waits in the input
// register, then the run tracking logic (two compares against the
// thresholds, two against the minimums, and the counter updates) produces
// the command into the output register. The sustained rate is one request
// per cycle while commands are taken, set by the single run state update
// per request. in_ready drops only while a command waits in the output
// register and out_ready is low. Bin numbers on the command are truncated
// to 9 bits. The user writes config only while idle; the block won't check.
// ---------------------------------------------------------------------------
module two_threshold_run_zero_suppressor_unit
    import ttrzs_pkg::*;
#(
    parameter int NUM_BINS = 512
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data,
    // sample requests
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [SAMPLE_W-1:0]  sample,
    input  logic                 first_bin,
    // zeroing commands
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ZBIN_W-1:0]    zero_from,
    output logic [ZBIN_W-1:0]    zero_to
);

    localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

    // configuration registers
    logic [SAMPLE_W-1:0] low_thr_reg;
    logic [SAMPLE_W-1:0] high_thr_reg;
    logic [CNT_W-1:0]    min_len_reg;
    logic [CNT_W-1:0]    min_high_reg;

    // input register
    logic                s1_valid_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic                s1_first_reg;

    // run state
    logic [BIN_W-1:0]    bin_index_reg, bin_index_next;
    logic [BIN_W-1:0]    run_start_reg, run_start_next;
    logic [CNT_W-1:0]    run_length_reg, run_length_next;
    logic [CNT_W-1:0]    high_count_reg, high_count_next;

    // output register
    logic                out_valid_reg;
    logic [ZBIN_W-1:0]   zero_from_reg, zero_from_next;
    logic [ZBIN_W-1:0]   zero_to_reg, zero_to_next;

    logic                in_take;
    logic                s1_adv;
    logic                emit;

    logic [BIN_W-1:0]    tb;
    logic [BIN_W-1:0]    rs_cur;
    logic [CNT_W-1:0]    rl_cur;
    logic [CNT_W-1:0]    hc_cur;
    logic [BIN_W-1:0]    rs_after;
    logic [CNT_W-1:0]    rl_after;
    logic [CNT_W-1:0]    hc_after;
    logic [SAMPLE_W-1:0] value;
    logic                is_low;
    logic                run_open;
    logic                run_weak;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_thr_reg  <= '0;
            high_thr_reg <= '0;
            min_len_reg  <= '0;
            min_high_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LOW_THR:  low_thr_reg  <= cfg_data;
                CFG_HIGH_THR: high_thr_reg <= cfg_data;
                CFG_MIN_LEN:  min_len_reg  <= cfg_data;
                CFG_MIN_HIGH: min_high_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_sample_reg <= sample;
            s1_first_reg  <= first_bin;
        end
    end

    // run tracking for the request in the input register
    always_comb
    begin
        // first bin restarts the channel before the sample is used
        tb     = s1_first_reg ? '0 : bin_index_reg;
        rs_cur = s1_first_reg ? '0 : run_start_reg;
        rl_cur = s1_first_reg ? '0 : run_length_reg;
        hc_cur = s1_first_reg ? '0 : high_count_reg;

        is_low   = (s1_sample_reg <= low_thr_reg);
        run_open = (rs_cur != '0);
        run_weak = (rl_cur <= min_len_reg) || (hc_cur <= min_high_reg);
        emit     = is_low && (!run_open || run_weak);

        zero_from_next = run_open ? ZBIN_W'(rs_cur) : ZBIN_W'(tb);
        zero_to_next   = ZBIN_W'(tb);

        rs_after = is_low ? '0 : rs_cur;
        rl_after = is_low ? '0 : rl_cur;
        hc_after = is_low ? '0 : hc_cur;

        // a zeroed closing sample counts as zero for the high test
        value = emit ? '0 : s1_sample_reg;

        run_length_next = sat_inc(rl_after);
        run_start_next  = (rs_after == '0) ? tb : rs_after;
        high_count_next = (value > high_thr_reg) ? sat_inc(hc_after) : hc_after;
        bin_index_next  = (tb < LAST_BIN) ? tb + 1'b1 : tb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_index_reg  <= '0;
            run_start_reg  <= '0;
            run_length_reg <= '0;
            high_count_reg <= '0;
        end
        else if (s1_adv)
        begin
            bin_index_reg  <= bin_index_next;
            run_start_reg  <= run_start_next;
            run_length_reg <= run_length_next;
            high_count_reg <= high_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= emit;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && emit)
        begin
            zero_from_reg <= zero_from_next;
            zero_to_reg   <= zero_to_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign zero_from = zero_from_reg;
    assign zero_to   = zero_to_reg;

endmodule

// ===== rtl/ttrzs_checker.sv =====
// ---------------------------------------------------------------------------
// ttrzs_checker
// port level checks of the run zero suppressor, bound to the top level
// ---------------------------------------------------------------------------
`include "two_threshold_run_zero_suppressor_unit_assert.svh"

module ttrzs_checker
    import ttrzs_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic [SAMPLE_W-1:0]  sample,
    input logic                 first_bin,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [ZBIN_W-1:0]    zero_from,
    input logic [ZBIN_W-1:0]    zero_to
);

    // a waiting request keeps its payload
    `TTRZS_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(sample) && $stable(first_bin))

    // a stalled command holds
    `TTRZS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(zero_from) && $stable(zero_to))

    // a command leaves only when taken
    `TTRZS_ASSERT_NOW(a_out_drop, $fell(out_valid), $past(out_ready))

    // input side stalls only behind a stalled command
    `TTRZS_ASSERT_NOW(a_in_stall, !in_ready, out_valid && !out_ready)

    // every new command comes from an earlier taken request, through the input register
    `TTRZS_ASSERT_NOW(a_out_src, $rose(out_valid), $past(in_valid && in_ready, 2))

endmodule

bind two_threshold_run_zero_suppressor_unit ttrzs_checker u_ttrzs_checker (.*);
